[hdl/dmct_pkg.sv]
// Shared types and codes of the Dirichlet-multinomial count table.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package dmct_pkg;

  localparam logic [2:0] FN_ADD = 3'd0;
  localparam logic [2:0] FN_DEL = 3'd1;
  localparam logic [2:0] FN_QONE = 3'd2;
  localparam logic [2:0] FN_ADDLIK = 3'd3;
  localparam logic [2:0] FN_QALL = 3'd4;
  localparam logic [2:0] FN_WPRIOR = 3'd5;
  localparam logic [2:0] FN_CLEAR = 3'd6;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;
  localparam logic [1:0] ST_UNDER = 2'd3;

  localparam logic [16:0] RATIO_ONE = 17'h10000;
  localparam logic [29:0] PSUM_MAX = 30'h3FFF_FFFF;

  typedef struct packed {
    logic [2:0]  func;
    logic [4:0]  class_id;
    logic [5:0]  symbol;
    logic [23:0] prior_value;
    logic        cls_ok;
    logic        sym_ok;
  } cmd_t;

  typedef struct packed {
    logic [4:0]  result_class;
    logic [16:0] ratio;
    logic        last;
    logic [1:0]  status;
  } res_t;

endpackage

[hdl/dmct_front.sv]
// Front end: accepts input items, checks class and symbol range, and holds them
// in a two-entry command queue. Depends on dmct_pkg.
`timescale 1ns / 1ps
module dmct_front import dmct_pkg::*; #(
  parameter int NUM_CLASSES = 32,
  parameter int NUM_SYMBOLS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [2:0]  in_func,
  input  logic [4:0]  in_class_id,
  input  logic [5:0]  in_symbol,
  input  logic [23:0] in_prior_value,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_pop
);

  cmd_t       q_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       acc;
  logic       pop;
  cmd_t       cin;

  assign in_full   = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign acc       = in_push && !in_full;
  assign pop       = cmd_pop && cmd_valid;

  always_comb begin
    cin.func        = in_func;
    cin.class_id    = in_class_id;
    cin.symbol      = in_symbol;
    cin.prior_value = in_prior_value;
    cin.cls_ok      = (32'(in_class_id) < NUM_CLASSES);
    cin.sym_ok      = (32'(in_symbol) < NUM_SYMBOLS);
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      q_r[wp_r] <= cin;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (acc) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(acc) - 2'(pop);
    end
  end

endmodule

[hdl/dmct_div.sv]
// Restoring divider for the Q1.16 ratio num * 65536 / den, one quotient bit a
// cycle, saturated to one. Depends on dmct_pkg.
`timescale 1ns / 1ps
module dmct_div import dmct_pkg::*; #(
  parameter int DW = 41
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [16:0]   quot
);

  logic [DW:0]   rem_r;
  logic [DW-1:0] den_r;
  logic [16:0]   q_r;
  logic [4:0]    step_r;
  logic          busy_r;
  logic          done_r;
  logic          ge;
  logic [DW:0]   rem_sub;

  assign ge      = (rem_r >= {1'b0, den_r});
  assign rem_sub = ge ? (rem_r - {1'b0, den_r}) : rem_r;
  assign done    = done_r;
  assign quot    = (q_r > RATIO_ONE) ? RATIO_ONE : q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 5'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        den_r <= den;
        rem_r <= {1'b0, num};
        q_r   <= 17'd0;
        if ({1'b0, num} >= {den, 1'b0}) begin
          q_r    <= RATIO_ONE;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          step_r <= 5'd17;
        end
      end else if (busy_r) begin
        q_r    <= {q_r[15:0], ge};
        rem_r  <= {rem_sub[DW-1:0], 1'b0};
        step_r <= step_r - 5'd1;
        if (step_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

[hdl/dmct_back.sv]
// Back end: count, total and prior storage with the operation sequencer and the
// ratio divider. Depends on dmct_pkg and dmct_div.
`timescale 1ns / 1ps
module dmct_back import dmct_pkg::*; #(
  parameter int NUM_CLASSES = 32,
  parameter int NUM_SYMBOLS = 64,
  parameter int COUNT_BITS  = 20
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_pop,
  input  logic       cfg_valid,
  input  logic [5:0] cfg_data,
  output logic       res_push,
  output res_t       res,
  input  logic       res_full
);

  localparam int CW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int SW    = $clog2(NUM_SYMBOLS);
  localparam int AW    = CW + SW;
  localparam int DEPTH = 2 ** AW;
  localparam int CB    = COUNT_BITS;
  localparam int PSW   = (24 + SW > 30) ? 24 + SW : 30;
  localparam int DW    = ((CB + 8 > PSW) ? CB + 8 : PSW) + 1;
  localparam int NQ    = (NUM_CLASSES < 32) ? NUM_CLASSES : 32;
  localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_SWEEP = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [CB-1:0]  cmem [DEPTH];
  logic [23:0]    pmem [2**SW];
  logic [CB-1:0]  tot_r [NUM_CLASSES];
  logic [CB-1:0]  cnt_rd_r;
  logic [23:0]    pr_rd_r;
  logic [PSW-1:0] prior_sum_r;
  logic [5:0]     active_r;
  logic [2:0]     state_r;
  cmd_t           cmd_r;
  res_t           res_r;
  logic [5:0]     idx_r;
  logic [AW-1:0]  clr_r;
  logic [SW-1:0]  sw_r;

  logic           qall;
  logic [CW-1:0]  cur_cls;
  logic           cur_ok;
  logic [SW-1:0]  sym;
  logic [CB-1:0]  cnt_v;
  logic [CB-1:0]  tot_v;
  logic [23:0]    pr_v;
  logic [PSW-1:0] ps_eff;
  logic [DW-1:0]  num;
  logic [DW-1:0]  den;
  logic [5:0]     nq;
  logic           is_last;
  logic [1:0]     add_st;
  logic           add_do;
  logic           del_ok;
  logic           div_start;
  logic           div_done;
  logic [16:0]    div_q;
  logic           cwe;
  logic [AW-1:0]  cwa;
  logic [CB-1:0]  cwd;
  logic           pwe;
  logic [SW-1:0]  pwa;
  logic [23:0]    pwd;

  assign qall    = (cmd_r.func == FN_QALL);
  assign cur_cls = qall ? CW'(idx_r) : CW'(cmd_r.class_id);
  assign cur_ok  = qall || cmd_r.cls_ok;
  assign sym     = SW'(cmd_r.symbol);
  assign cnt_v   = (cur_ok && cmd_r.sym_ok) ? cnt_rd_r : '0;
  assign tot_v   = cur_ok ? tot_r[cur_cls] : '0;
  assign pr_v    = cmd_r.sym_ok ? pr_rd_r : 24'd0;
  assign ps_eff  = (prior_sum_r > PSW'(PSUM_MAX)) ? PSW'(PSUM_MAX) : prior_sum_r;
  assign num     = DW'(pr_v) + (DW'(cnt_v) << 8);
  assign den     = DW'(ps_eff) + (DW'(tot_v) << 8);
  assign nq      = (active_r == 6'd0) ? 6'd1 :
                   ((32'(active_r) > NQ) ? 6'(NQ) : active_r);
  assign is_last = !qall || (idx_r == nq - 6'd1);
  assign add_st  = (cur_ok && cmd_r.sym_ok && (tot_v == CNT_MAX || cnt_v == CNT_MAX))
                   ? ST_SAT : ST_OK;
  assign add_do  = cur_ok && cmd_r.sym_ok && (add_st == ST_OK);
  assign del_ok  = (cnt_v != '0) && (tot_v != '0);

  assign cmd_pop   = (state_r == S_IDLE) && cmd_valid;
  assign res_push  = (state_r == S_EMIT) && !res_full;
  assign res       = res_r;
  assign div_start = (state_r == S_EXEC) && (den != '0) &&
                     (qall || cmd_r.func == FN_QONE || cmd_r.func == FN_ADDLIK);

  dmct_div #(.DW(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quot  (div_q)
  );

  always_comb begin
    cwe = 1'b0;
    cwa = {cur_cls, sym};
    cwd = '0;
    pwe = 1'b0;
    pwa = sym;
    pwd = cmd_r.prior_value;
    if (state_r == S_CLR) begin
      cwe = 1'b1;
      cwa = clr_r;
      pwe = 1'b1;
      pwa = clr_r[SW-1:0];
      pwd = 24'd0;
    end else if (state_r == S_SWEEP) begin
      cwe = 1'b1;
      cwa = {cur_cls, sw_r};
    end else if (state_r == S_EXEC) begin
      if ((cmd_r.func == FN_ADD || cmd_r.func == FN_ADDLIK) && add_do) begin
        cwe = 1'b1;
        cwd = cnt_v + CB'(1);
      end else if (cmd_r.func == FN_DEL && cur_ok && cmd_r.sym_ok && del_ok) begin
        cwe = 1'b1;
        cwd = cnt_v - CB'(1);
      end
      pwe = (cmd_r.func == FN_WPRIOR) && cmd_r.sym_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cwe) cmem[cwa] <= cwd;
    if (pwe) pmem[pwa] <= pwd;
    cnt_rd_r <= cmem[{cur_cls, sym}];
    pr_rd_r  <= pmem[sym];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      prior_sum_r <= '0;
      active_r    <= 6'd32;
      idx_r       <= 6'd0;
      sw_r        <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) tot_r[i] <= '0;
    end else begin
      if (cfg_valid) active_r <= cfg_data;
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r   <= cmd;
            idx_r   <= 6'd0;
            state_r <= S_ISSUE;
          end
        end
        S_ISSUE: state_r <= S_EXEC;
        S_EXEC: begin
          res_r.result_class <= qall ? idx_r[4:0] : cmd_r.class_id;
          res_r.ratio        <= 17'd0;
          res_r.last         <= is_last;
          res_r.status       <= ST_OK;
          state_r            <= S_EMIT;
          case (cmd_r.func)
            FN_ADD: begin
              res_r.status <= add_st;
              if (add_do) tot_r[cur_cls] <= tot_v + CB'(1);
            end
            FN_DEL: begin
              if (cur_ok && cmd_r.sym_ok) begin
                if (del_ok) tot_r[cur_cls] <= tot_v - CB'(1);
                else res_r.status <= ST_UNDER;
              end
            end
            FN_QONE, FN_QALL: begin
              if (den == '0) res_r.status <= ST_ZDEN;
              else state_r <= S_DIV;
            end
            FN_ADDLIK: begin
              if (add_do) tot_r[cur_cls] <= tot_v + CB'(1);
              if (add_st != ST_OK) res_r.status <= add_st;
              else if (den == '0) res_r.status <= ST_ZDEN;
              if (den != '0) state_r <= S_DIV;
            end
            FN_WPRIOR: begin
              if (cmd_r.sym_ok) begin
                prior_sum_r <= prior_sum_r - PSW'(pr_rd_r) + PSW'(cmd_r.prior_value);
              end
            end
            FN_CLEAR: begin
              if (cur_ok) begin
                tot_r[cur_cls] <= '0;
                sw_r           <= '0;
                state_r        <= S_SWEEP;
              end
            end
            default: ;
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            res_r.ratio <= div_q;
            state_r     <= S_EMIT;
          end
        end
        S_SWEEP: begin
          sw_r <= sw_r + SW'(1);
          if (sw_r == SW'(NUM_SYMBOLS - 1)) state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!res_full) begin
            if (res_r.last) begin
              state_r <= S_IDLE;
            end else begin
              idx_r   <= idx_r + 6'd1;
              state_r <= S_ISSUE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[hdl/dmct_outq.sv]
// Four-entry result queue between the back end and the result ports.
// Depends on dmct_pkg.
`timescale 1ns / 1ps
module dmct_outq import dmct_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t din,
  output logic full,
  output logic empty,
  input  logic pop,
  output res_t dout
);

  res_t       q_r [4];
  logic [1:0] wp_r;
  logic [1:0] rp_r;
  logic [2:0] cnt_r;
  logic       wr;
  logic       rd;

  assign full  = (cnt_r == 3'd4);
  assign empty = (cnt_r == 3'd0);
  assign dout  = q_r[rp_r];
  assign wr    = push && !full;
  assign rd    = pop && !empty;

  always_ff @(posedge clk) begin
    if (wr) q_r[wp_r] <= din;
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      if (wr) wp_r <= wp_r + 2'd1;
      if (rd) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(wr) - 3'(rd);
    end
  end

endmodule

[hdl/dirichlet_multinomial_count_table.sv]
// Dirichlet-multinomial count table: predictive ratio per class and symbol.
// Add, delete, write prior and unused codes give their result without the divider; a query
// takes its ratio from the 17-step divider, whose steps are skipped if the ratio saturates at
// once; a query over all active classes runs it once per class. Clearing a class also sweeps
// its NUM_SYMBOLS count entries. Items are handled one at a time. Reset is synchronous; after
// it, 2^(class bits + symbol bits) entries (2048 by default) are cleared before any item runs.
`timescale 1ns / 1ps
module dirichlet_multinomial_count_table import dmct_pkg::*; #(
  parameter int NUM_CLASSES = 32,
  parameter int NUM_SYMBOLS = 64,
  parameter int COUNT_BITS  = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [2:0]  in_func,
  input  logic [4:0]  in_class_id,
  input  logic [5:0]  in_symbol,
  input  logic [23:0] in_prior_value,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [4:0]  out_result_class,
  output logic [16:0] out_ratio,
  output logic        out_last,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  logic res_push;
  res_t res_in;
  logic res_full;
  res_t res_out;

  assign cfg_ready        = 1'b1;
  assign out_result_class = res_out.result_class;
  assign out_ratio        = res_out.ratio;
  assign out_last         = res_out.last;
  assign out_status       = res_out.status;

  dmct_front #(.NUM_CLASSES(NUM_CLASSES), .NUM_SYMBOLS(NUM_SYMBOLS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_func        (in_func),
    .in_class_id    (in_class_id),
    .in_symbol      (in_symbol),
    .in_prior_value (in_prior_value),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop)
  );

  dmct_back #(
    .NUM_CLASSES (NUM_CLASSES),
    .NUM_SYMBOLS (NUM_SYMBOLS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .res_push  (res_push),
    .res       (res_in),
    .res_full  (res_full)
  );

  dmct_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .empty (out_empty),
    .pop   (out_pop),
    .dout  (res_out)
  );

endmodule

[tb/dirichlet_multinomial_count_table_tb.sv]
// Testbench for the Dirichlet-multinomial count table: a queue-fed driver, a popping monitor
// and a predictor of counts, priors and ratios that checks every result item in order.
// Depends on dmct_pkg and dirichlet_multinomial_count_table.
`timescale 1ns / 1ps
module dirichlet_multinomial_count_table_tb;
  import dmct_pkg::*;

  localparam logic [2:0] FN_SPARE = 3'd7;
  localparam logic [19:0] CNT_MAX = 20'hFFFFF;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    logic [2:0]  func;
    logic [4:0]  cls;
    logic [5:0]  sym;
    logic [23:0] pv;
  } item_t;

  logic clk, rst_n;
  logic in_push, in_full;
  logic [2:0] in_func;
  logic [4:0] in_class_id;
  logic [5:0] in_symbol;
  logic [23:0] in_prior_value;
  logic out_empty, out_pop;
  logic [4:0] out_result_class;
  logic [16:0] out_ratio;
  logic out_last;
  logic [1:0] out_status;
  logic cfg_valid, cfg_ready;
  logic [5:0] cfg_data;

  item_t pending[$];
  res_t expected_res[$];

  logic [19:0] sym_count [32][64];
  logic [19:0] cls_total [32];
  logic [23:0] prior_tab [64];
  longint unsigned prior_total;
  logic [5:0] active_cls;

  int errors = 0;
  int gap_max = 6;
  int idle_cycles = 0;
  bit in_taken = 0, out_taken = 0, cfg_taken = 0, offering = 0, start_hold = 0;
  int push_gap = 0, pop_gap = 0, hold_left = 0;

  dirichlet_multinomial_count_table DUT (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_func(in_func), .in_class_id(in_class_id),
    .in_symbol(in_symbol), .in_prior_value(in_prior_value),
    .out_empty(out_empty), .out_pop(out_pop), .out_result_class(out_result_class),
    .out_ratio(out_ratio), .out_last(out_last), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic logic [16:0] ratio_for(input int c, input int s, output logic [1:0] st);
    longint unsigned num, den, q, ps;
    ps = (prior_total > 64'(PSUM_MAX)) ? 64'(PSUM_MAX) : prior_total;
    num = prior_tab[s] + (longint'(sym_count[c][s]) << 8);
    den = ps + (longint'(cls_total[c]) << 8);
    st = ST_OK;
    if (den == 0) begin
      st = ST_ZDEN;
      return '0;
    end
    q = (num << 16) / den;
    return (q > 65536) ? RATIO_ONE : q[16:0];
  endfunction

  function automatic logic [1:0] count_up(input int c, input int s);
    if (cls_total[c] >= CNT_MAX || sym_count[c][s] >= CNT_MAX) return ST_SAT;
    sym_count[c][s]++;
    cls_total[c]++;
    return ST_OK;
  endfunction

  task automatic predict_item(input item_t it);
    logic [1:0] st, st2;
    logic [16:0] r;
    int n;
    int c, s;
    c = it.cls;
    s = it.sym;
    st = ST_OK;
    r = '0;
    case (it.func)
      FN_ADD: st = count_up(c, s);
      FN_DEL: begin
        if (sym_count[c][s] == 0 || cls_total[c] == 0) st = ST_UNDER;
        else begin
          sym_count[c][s]--;
          cls_total[c]--;
        end
      end
      FN_QONE: r = ratio_for(c, s, st);
      FN_ADDLIK: begin
        r = ratio_for(c, s, st);
        st2 = count_up(c, s);
        if (st2 != ST_OK) st = st2;
      end
      FN_QALL: begin
        n = active_cls;
        if (n < 1) n = 1;
        if (n > 32) n = 32;
        for (int i = 0; i < n; i++) begin
          r = ratio_for(i, s, st);
          expected_res.push_back('{5'(i), r, (i + 1 == n), st});
        end
        return;
      end
      FN_WPRIOR: begin
        prior_total = prior_total - prior_tab[s] + it.pv;
        prior_tab[s] = it.pv;
      end
      FN_CLEAR: begin
        for (int j = 0; j < 64; j++) sym_count[c][j] = '0;
        cls_total[c] = '0;
      end
      default: ;
    endcase
    expected_res.push_back('{it.cls, r, 1'b1, st});
  endtask

  function automatic void queue_item(input logic [2:0] f, input logic [4:0] c,
                                     input logic [5:0] s, input logic [23:0] p);
    pending.push_back('{f, c, s, p});
  endfunction

  task automatic queue_random(input int count);
    int k;
    logic [2:0] f;
    logic [4:0] c;
    logic [5:0] s;
    logic [23:0] p;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      if (k < 30) f = FN_ADD;
      else if (k < 40) f = FN_DEL;
      else if (k < 58) f = FN_QONE;
      else if (k < 73) f = FN_ADDLIK;
      else if (k < 77) f = FN_QALL;
      else if (k < 88) f = FN_WPRIOR;
      else if (k < 93) f = FN_CLEAR;
      else f = FN_SPARE;
      c = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 3));
      s = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
      p = ($urandom_range(0, 1) == 0) ? 24'($urandom) : 24'($urandom_range(0, 4095));
      queue_item(f, c, s, p);
    end
  endtask

  task automatic drain;
    wait (pending.size() == 0 && expected_res.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_active(input logic [5:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    active_cls = v;
    cfg_taken = 1;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        in_taken = 0;
        void'(pending.pop_front());
        offering = 0;
        push_gap = $urandom_range(0, gap_max);
      end
      if (!offering) begin
        if (push_gap > 0) push_gap--;
        else if (pending.size() > 0) begin
          offering = 1;
          in_func <= pending[0].func;
          in_class_id <= pending[0].cls;
          in_symbol <= pending[0].sym;
          in_prior_value <= pending[0].pv;
        end
      end
      in_push <= offering;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) begin
      predict_item(pending[0]);
      in_taken = 1;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (start_hold) begin
        start_hold = 0;
        hold_left = 3000;
      end
      if (out_taken) begin
        out_taken = 0;
        pop_gap = $urandom_range(0, gap_max);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (pop_gap > 0) begin
        pop_gap--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_pop && !out_empty) begin
      out_taken = 1;
      if (expected_res.size() == 0) begin
        $display("%0t: unexpected result class=%0d ratio=%0d last=%0b status=%0d", $time,
                 out_result_class, out_ratio, out_last, out_status);
        errors++;
      end else begin
        want = expected_res.pop_front();
        if (want.result_class !== out_result_class) begin
          $display("%0t: result_class expected %0d actual %0d", $time, want.result_class,
                   out_result_class);
          errors++;
        end
        if (want.ratio !== out_ratio) begin
          $display("%0t: ratio expected %0d actual %0d", $time, want.ratio, out_ratio);
          errors++;
        end
        if (want.last !== out_last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, out_last);
          errors++;
        end
        if (want.status !== out_status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || cfg_taken) idle_cycles = 0;
    else idle_cycles++;
    cfg_taken = 0;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [5:0] settings [6];
    settings = '{6'd1, 6'd63, 6'd0, 6'd5, 6'd32, 6'd17};
    rst_n = 1'b0;
    in_push = 1'b0;
    in_func = '0;
    in_class_id = '0;
    in_symbol = '0;
    in_prior_value = '0;
    out_pop = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    for (int c = 0; c < 32; c++) begin
      cls_total[c] = '0;
      for (int s = 0; s < 64; s++) sym_count[c][s] = '0;
    end
    for (int s = 0; s < 64; s++) prior_tab[s] = '0;
    prior_total = 0;
    active_cls = 6'd32;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    start_hold = 1;
    queue_item(FN_QONE, 5'd0, 6'd0, 24'd0);
    queue_item(FN_ADDLIK, 5'd0, 6'd0, 24'd0);
    queue_item(FN_ADD, 5'd0, 6'd0, 24'hFFFFFF);
    queue_item(FN_ADD, 5'd31, 6'd63, 24'd0);
    queue_item(FN_DEL, 5'd1, 6'd5, 24'd0);
    queue_item(FN_WPRIOR, 5'd0, 6'd0, 24'hFFFFFF);
    queue_item(FN_WPRIOR, 5'd31, 6'd63, 24'd1);
    queue_item(FN_WPRIOR, 5'd0, 6'd10, 24'd0);
    queue_item(FN_QONE, 5'd0, 6'd0, 24'd0);
    queue_item(FN_QONE, 5'd31, 6'd63, 24'd0);
    queue_item(FN_QONE, 5'd5, 6'd63, 24'd0);
    queue_item(FN_ADDLIK, 5'd31, 6'd63, 24'd0);
    queue_item(FN_QALL, 5'd0, 6'd0, 24'd0);
    queue_item(FN_DEL, 5'd0, 6'd0, 24'd0);
    queue_item(FN_DEL, 5'd0, 6'd0, 24'd0);
    queue_item(FN_DEL, 5'd0, 6'd0, 24'd0);
    queue_item(FN_CLEAR, 5'd31, 6'd0, 24'd0);
    queue_item(FN_QONE, 5'd31, 6'd63, 24'd0);
    queue_item(FN_SPARE, 5'd17, 6'd33, 24'hA5A5A5);
    queue_item(FN_WPRIOR, 5'd10, 6'd0, 24'h0ABCDE);
    queue_item(FN_QALL, 5'd3, 6'd63, 24'd0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_active(settings[ph]);
      gap_max = (ph == 2) ? 0 : 6;
      queue_random(16);
      drain();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/dmct_pkg.sv
hdl/dmct_front.sv
hdl/dmct_div.sv
hdl/dmct_back.sv
hdl/dmct_outq.sv
hdl/dirichlet_multinomial_count_table.sv
tb/dirichlet_multinomial_count_table_tb.sv
